@@ rtl/core/fhcv_pkg.sv @@
`timescale 1ns / 1ps

package fhcv_pkg;

    localparam int HEADER_BYTES  = 32;
    localparam int PAYLOAD_BYTES = 432;
    localparam int CRC_SPAN      = HEADER_BYTES + PAYLOAD_BYTES;
    localparam int MSG_SIZE      = CRC_SPAN + 4;
    localparam int POS_W         = $clog2(MSG_SIZE + 1);

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_XOR  = 32'hFFFFFFFF;

    localparam logic [POS_W-1:0] POS_CRC_SPAN = POS_W'(CRC_SPAN);
    localparam logic [POS_W-1:0] POS_MSG_SIZE = POS_W'(MSG_SIZE);
    localparam logic [POS_W-1:0] POS_VERSION  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(5);
    localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(18);
    localparam logic [POS_W-1:0] POS_LEN_LO   = POS_W'(19);
    localparam logic [POS_W-1:0] POS_MAGIC_END = POS_W'(4);
    localparam logic [15:0] LENGTH_EXPECTED = 16'(PAYLOAD_BYTES);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SIZE    = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_TYPE    = 3'd4,
        ST_LENGTH  = 3'd5,
        ST_CRC     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CFG_MAGIC_WORD   = 2'd0,
        CFG_VERSION      = 2'd1,
        CFG_MSG_TYPE     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  version_expected;
        logic [7:0]  msg_type_expected;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] computed_crc;
    } result_t;

endpackage

@@ rtl/core/fhcv_if.sv @@
`timescale 1ns / 1ps

interface fhcv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface fhcv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] computed_crc;

    modport source (output valid, output status, output computed_crc, input ready);
    modport sink   (input valid, input status, input computed_crc, output ready);
endinterface

@@ rtl/core/fhcv_crc_step.sv @@
`timescale 1ns / 1ps

module fhcv_crc_step
    import fhcv_pkg::*;
(
    input  logic [31:0] crc_in,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);

    logic [31:0] acc;

    // one reflected CRC-32 byte update, eight bit steps folded into an XOR tree
    always_comb
    begin
        acc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        crc_out = acc;
    end

endmodule

@@ rtl/core/fhcv_msg_state.sv @@
`timescale 1ns / 1ps

module fhcv_msg_state
    import fhcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic [7:0] byte_value,
    input  logic       last_byte,
    output result_t    result
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      rx_crc_reg, rx_crc_next;
    logic [15:0]      len_reg, len_next;
    logic             magic_bad_reg, magic_bad_next;
    logic             version_bad_reg, version_bad_next;
    logic             type_bad_reg, type_bad_next;
    logic             overlong_reg, overlong_next;
    logic [31:0]      crc_upd;
    logic [7:0]       magic_want;
    logic [31:0]      crc_final;

    fhcv_crc_step u_crc_step (
        .crc_in  (crc_reg),
        .data    (byte_value),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        case (pos_reg[1:0])
            2'd0:    magic_want = cfg.magic_word[31:24];
            2'd1:    magic_want = cfg.magic_word[23:16];
            2'd2:    magic_want = cfg.magic_word[15:8];
            default: magic_want = cfg.magic_word[7:0];
        endcase
    end

    always_comb
    begin
        pos_next         = pos_reg;
        crc_next         = crc_reg;
        rx_crc_next      = rx_crc_reg;
        len_next         = len_reg;
        magic_bad_next   = magic_bad_reg;
        version_bad_next = version_bad_reg;
        type_bad_next    = type_bad_reg;
        overlong_next    = overlong_reg;

        // drop bytes beyond the full message size
        if (pos_reg >= POS_MSG_SIZE)
        begin
            overlong_next = 1'b1;
        end
        else
        begin
            if (pos_reg < POS_CRC_SPAN)
                crc_next = crc_upd;
            else
                rx_crc_next = {rx_crc_reg[23:0], byte_value};

            if (pos_reg < POS_MAGIC_END)
            begin
                if (byte_value != magic_want)
                    magic_bad_next = 1'b1;
            end
            else if (pos_reg == POS_VERSION)
            begin
                if (byte_value != cfg.version_expected)
                    version_bad_next = 1'b1;
            end
            else if (pos_reg == POS_TYPE)
            begin
                if (byte_value != cfg.msg_type_expected)
                    type_bad_next = 1'b1;
            end
            else if (pos_reg == POS_LEN_HI || pos_reg == POS_LEN_LO)
            begin
                len_next = {len_reg[7:0], byte_value};
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    assign crc_final = crc_next ^ CRC_XOR;

    always_comb
    begin
        result.computed_crc = crc_final;
        if (overlong_next || pos_next != POS_MSG_SIZE)
            result.status = ST_SIZE;
        else if (magic_bad_next)
            result.status = ST_MAGIC;
        else if (version_bad_next)
            result.status = ST_VERSION;
        else if (type_bad_next)
            result.status = ST_TYPE;
        else if (len_next != LENGTH_EXPECTED)
            result.status = ST_LENGTH;
        else if (rx_crc_next != crc_final)
            result.status = ST_CRC;
        else
            result.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            crc_reg         <= CRC_INIT;
            rx_crc_reg      <= '0;
            len_reg         <= '0;
            magic_bad_reg   <= 1'b0;
            version_bad_reg <= 1'b0;
            type_bad_reg    <= 1'b0;
            overlong_reg    <= 1'b0;
        end
        else if (step)
        begin
            // clear all message state after the final byte
            if (last_byte)
            begin
                pos_reg         <= '0;
                crc_reg         <= CRC_INIT;
                rx_crc_reg      <= '0;
                len_reg         <= '0;
                magic_bad_reg   <= 1'b0;
                version_bad_reg <= 1'b0;
                type_bad_reg    <= 1'b0;
                overlong_reg    <= 1'b0;
            end
            else
            begin
                pos_reg         <= pos_next;
                crc_reg         <= crc_next;
                rx_crc_reg      <= rx_crc_next;
                len_reg         <= len_next;
                magic_bad_reg   <= magic_bad_next;
                version_bad_reg <= version_bad_next;
                type_bad_reg    <= type_bad_next;
                overlong_reg    <= overlong_next;
            end
        end
    end

endmodule

@@ rtl/core/frame_header_crc_verifier.sv @@
`timescale 1ns / 1ps

// Byte-stream frame verifier: one byte per transaction on the input channel, last_byte
// marking the end of a message of 32 header bytes, 432 payload bytes and a big-endian
// CRC-32 trailer. Each byte passes an input register and then the CRC and header-field
// logic; a byte is accepted every cycle while the input is not stalled. The status and
// out.valid for a message are loaded into the output register together, when its final
// byte leaves the input register. Input only stalls when a finished status is still
// waiting in the output register and the next final byte is ready to leave the input
// register. Write the magic word, version and message type through the configuration
// port only while no message is in flight.

module frame_header_crc_verifier
    import fhcv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    fhcv_in_if.sink           in,
    fhcv_out_if.source        out,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    cfg_t       cfg_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_adv;
    logic       step;
    result_t    result;
    logic       out_valid_reg;
    result_t    out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MAGIC_WORD: cfg_reg.magic_word        <= cfg_data;
                CFG_VERSION:    cfg_reg.version_expected  <= cfg_data[7:0];
                CFG_MSG_TYPE:   cfg_reg.msg_type_expected <= cfg_data[7:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // hold a final byte while the previous status has not been taken
    assign s1_adv   = !s1_last_reg || !out_valid_reg || out.ready;
    assign step     = s1_valid_reg && s1_adv;
    assign in.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in.ready)
        begin
            s1_valid_reg <= in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in.valid && in.ready)
        begin
            s1_byte_reg <= in.byte_value;
            s1_last_reg <= in.last_byte;
        end
    end

    fhcv_msg_state u_msg_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .step       (step),
        .byte_value (s1_byte_reg),
        .last_byte  (s1_last_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && s1_last_reg)
        begin
            out_data_reg <= result;
        end
    end

    assign out.valid        = out_valid_reg;
    assign out.status       = out_data_reg.status;
    assign out.computed_crc = out_data_reg.computed_crc;

    a_final_byte_gives_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        step && s1_last_reg |=> out_valid_reg
    ) else $error("final byte did not load a status");

    a_stall_only_on_full_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in.ready |-> s1_valid_reg && s1_last_reg && out_valid_reg && !out.ready
    ) else $error("input stalled without a pending status");

    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out.ready |=> out_valid_reg && $stable(out_data_reg)
    ) else $error("pending status overwritten");

endmodule

@@ dv/tb_frame_header_crc_verifier.sv @@
`timescale 1ns / 1ps

module tb_frame_header_crc_verifier;
    import fhcv_pkg::*;

    localparam logic [1:0] CFG_INDEX_UNUSED = 2'd3;

    localparam logic [4:0] FLAW_NONE    = 5'b00000;
    localparam logic [4:0] FLAW_MAGIC   = 5'b00001;
    localparam logic [4:0] FLAW_VERSION = 5'b00010;
    localparam logic [4:0] FLAW_TYPE    = 5'b00100;
    localparam logic [4:0] FLAW_LENGTH  = 5'b01000;
    localparam logic [4:0] FLAW_CRC     = 5'b10000;

    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int BURST_FRAMES  = 24;
    localparam int RANDOM_BYTES  = 240;
    localparam int RANDOM_FRAMES = 12;

    typedef enum logic [1:0] {
        FRAME_FULL  = 2'd0,
        FRAME_SHORT = 2'd1,
        FRAME_LONG  = 2'd2
    } frame_shape_t;

    typedef enum logic [1:0] {
        FILL_ZERO   = 2'd0,
        FILL_ONES   = 2'd1,
        FILL_RANDOM = 2'd2
    } fill_t;

    typedef enum logic [1:0] {
        TRAFFIC_STEADY      = 2'd0,
        TRAFFIC_SENDER_GAPS = 2'd1,
        TRAFFIC_SINK_STALLS = 2'd2,
        TRAFFIC_BOTH        = 2'd3
    } traffic_t;

    typedef struct packed {
        logic         set_cfg;
        cfg_t         cfg;
        frame_shape_t shape;
        logic [15:0]  extent;
        logic [4:0]   flaws;
        fill_t        fill;
        logic         typed;
        status_t      status;
    } frame_row_t;

    logic clk;
    logic rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    fhcv_in_if  in_ch ();
    fhcv_out_if out_ch ();

    frame_header_crc_verifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch),
        .out       (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Frame checker model state
    cfg_t             active_cfg;
    logic [POS_W-1:0] frame_pos;
    logic [31:0]      running_crc;
    logic [31:0]      trailer_crc;
    logic [15:0]      length_seen;
    logic             magic_bad;
    logic             version_bad;
    logic             type_bad;
    logic             overlong;

    result_t  expected_results [$];
    logic     typed_pending;
    status_t  typed_status;

    traffic_t traffic_mode;
    logic     hold_request;
    int       hold_left;
    int       errors;
    int       frames_sent;
    int       accepted_bytes;
    int       statuses_checked;
    int       status_seen [7];

    // Full-length rows each reach one status past the size check; flaw pairs check priority.
    frame_row_t directed_rows [10] = '{
        '{1'b0, '0, FRAME_SHORT, 16'd1, FLAW_NONE, FILL_ZERO, 1'b1, ST_SIZE},
        '{1'b0, '0, FRAME_FULL, 16'd0, FLAW_NONE, FILL_ZERO, 1'b1, ST_OK},
        '{1'b1, '{32'hFFFF_FFFF, 8'hFF, 8'hFF}, FRAME_FULL, 16'd0,
            FLAW_MAGIC | FLAW_TYPE | FLAW_CRC, FILL_ONES, 1'b1, ST_MAGIC},
        '{1'b0, '0, FRAME_FULL, 16'd0, FLAW_VERSION | FLAW_LENGTH, FILL_ONES, 1'b1,
            ST_VERSION},
        '{1'b1, '{32'hA5C3_0F96, 8'h01, 8'h80}, FRAME_FULL, 16'd0,
            FLAW_TYPE | FLAW_CRC, FILL_RANDOM, 1'b1, ST_TYPE},
        '{1'b0, '0, FRAME_FULL, 16'd0, FLAW_LENGTH | FLAW_CRC, FILL_RANDOM, 1'b1, ST_LENGTH},
        '{1'b0, '0, FRAME_FULL, 16'd0, FLAW_CRC, FILL_RANDOM, 1'b1, ST_CRC},
        '{1'b0, '0, FRAME_LONG, 16'd3, FLAW_MAGIC, FILL_RANDOM, 1'b1, ST_SIZE},
        '{1'b0, '0, FRAME_SHORT, 16'd4, FLAW_MAGIC, FILL_RANDOM, 1'b1, ST_SIZE},
        '{1'b1, '0, FRAME_SHORT, 16'd20, FLAW_NONE, FILL_RANDOM, 1'b0, ST_OK}
    };

    always #2 clk = ~clk;

    initial
    begin
        #1000000;
        $display("timeout at %0t with %0d statuses outstanding", $time,
                 expected_results.size());
        $display("tb_frame_header_crc_verifier failed");
        $finish;
    end

    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        return c;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic clear_frame();
        frame_pos   = '0;
        running_crc = CRC_INIT;
        trailer_crc = '0;
        length_seen = '0;
        magic_bad   = 1'b0;
        version_bad = 1'b0;
        type_bad    = 1'b0;
        overlong    = 1'b0;
    endtask

    // Advance the frame model by one accepted byte; queue a status on the final byte.
    task automatic absorb_byte(input logic [7:0] b, input logic is_last);
        result_t r;
        int p;
        p = int'(frame_pos);
        if (p >= MSG_SIZE)
        begin
            overlong = 1'b1;
        end
        else
        begin
            accepted_bytes++;
            if (p < CRC_SPAN)
                running_crc = crc_update(running_crc, b);
            else
                trailer_crc = {trailer_crc[23:0], b};
            if (p < 4)
            begin
                if (b != 8'(active_cfg.magic_word >> (24 - 8 * p)))
                    magic_bad = 1'b1;
            end
            else if (p == 4)
            begin
                if (b != active_cfg.version_expected)
                    version_bad = 1'b1;
            end
            else if (p == 5)
            begin
                if (b != active_cfg.msg_type_expected)
                    type_bad = 1'b1;
            end
            else if (p == 18 || p == 19)
            begin
                length_seen = {length_seen[7:0], b};
            end
            frame_pos = frame_pos + 1'b1;
        end
        if (is_last)
        begin
            r.computed_crc = running_crc ^ CRC_XOR;
            if (overlong || int'(frame_pos) != MSG_SIZE)
                r.status = ST_SIZE;
            else if (magic_bad)
                r.status = ST_MAGIC;
            else if (version_bad)
                r.status = ST_VERSION;
            else if (type_bad)
                r.status = ST_TYPE;
            else if (length_seen != 16'(PAYLOAD_BYTES))
                r.status = ST_LENGTH;
            else if (trailer_crc != r.computed_crc)
                r.status = ST_CRC;
            else
                r.status = ST_OK;
            if (typed_pending)
            begin
                r.status = typed_status;
                typed_pending = 1'b0;
            end
            expected_results.push_back(r);
            clear_frame();
        end
    endtask

    function automatic int sender_idle_pct();
        case (traffic_mode)
            TRAFFIC_SENDER_GAPS: return 69;
            TRAFFIC_BOTH: return 30;
            default: return 0;
        endcase
    endfunction

    // Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < sender_idle_pct())
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_value <= b;
        in_ch.last_byte  <= is_last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        absorb_byte(b, is_last);
        @(negedge clk);
    endtask

    task automatic send_frame(input frame_shape_t shape, input int extent,
                              input logic [4:0] flaws, input fill_t fill);
        logic [7:0]  image [MSG_SIZE];
        logic [31:0] crc;
        int total;
        int sel;
        for (int i = 0; i < MSG_SIZE; i++)
            image[i] = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
        for (int i = 0; i < 4; i++)
            image[i] = 8'(active_cfg.magic_word >> (24 - 8 * i));
        image[4]  = active_cfg.version_expected;
        image[5]  = active_cfg.msg_type_expected;
        image[18] = 8'(PAYLOAD_BYTES >> 8);
        image[19] = 8'(PAYLOAD_BYTES);
        // Flip one bit per flawed field so the mismatch is certain.
        if (flaws & FLAW_MAGIC)
        begin
            sel = int'($urandom_range(3));
            image[sel] = image[sel] ^ 8'(1 << $urandom_range(7));
        end
        if (flaws & FLAW_VERSION)
            image[4] = image[4] ^ 8'(1 << $urandom_range(7));
        if (flaws & FLAW_TYPE)
            image[5] = image[5] ^ 8'(1 << $urandom_range(7));
        if (flaws & FLAW_LENGTH)
        begin
            sel = 18 + int'($urandom_range(1));
            image[sel] = image[sel] ^ 8'(1 << $urandom_range(7));
        end
        crc = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++)
            crc = crc_update(crc, image[i]);
        crc = crc ^ CRC_XOR;
        for (int i = 0; i < 4; i++)
            image[CRC_SPAN + i] = 8'(crc >> (24 - 8 * i));
        if (flaws & FLAW_CRC)
        begin
            sel = CRC_SPAN + int'($urandom_range(3));
            image[sel] = image[sel] ^ 8'(1 << $urandom_range(7));
        end
        case (shape)
            FRAME_SHORT: total = extent;
            FRAME_LONG: total = MSG_SIZE + extent;
            default: total = MSG_SIZE;
        endcase
        traffic_mode = traffic_t'((frames_sent / 3) % 4);
        for (int i = 0; i < total; i++)
            send_byte((i < MSG_SIZE) ? image[i] : 8'($urandom), i == total - 1);
        frames_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write all registers back to back, plus one write to the unused index.
    task automatic load_config(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAGIC_WORD;
        cfg_data  <= c.magic_word;
        @(negedge clk);
        cfg_index <= CFG_VERSION;
        cfg_data  <= {24'($urandom), c.version_expected};
        @(negedge clk);
        cfg_index <= CFG_MSG_TYPE;
        cfg_data  <= {24'($urandom), c.msg_type_expected};
        @(negedge clk);
        cfg_index <= CFG_INDEX_UNUSED;
        cfg_data  <= $urandom;
        @(negedge clk);
        cfg_we <= 1'b0;
        active_cfg = c;
        @(negedge clk);
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (traffic_mode)
                    TRAFFIC_SINK_STALLS: out_ch.ready <= ($urandom_range(99) >= 69);
                    TRAFFIC_BOTH: out_ch.ready <= ($urandom_range(99) >= 30);
                    default: out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected status transaction, actual status %0d crc %08h",
                         $time, out_ch.status, out_ch.computed_crc);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, out_ch.status);
                    errors++;
                end
                if (out_ch.computed_crc !== want.computed_crc)
                begin
                    $display("%0t: computed_crc mismatch, expected %08h actual %08h",
                             $time, want.computed_crc, out_ch.computed_crc);
                    errors++;
                end
                status_seen[int'(want.status)]++;
                statuses_checked++;
            end
        end
    end

    initial
    begin
        int roll;
        int random_start_bytes;
        int random_start_frames;
        logic pressure_done;
        cfg_t c;
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_MAGIC_WORD;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.byte_value = '0;
        in_ch.last_byte  = 1'b0;
        hold_request     = 1'b0;
        typed_pending    = 1'b0;
        typed_status     = ST_OK;
        traffic_mode     = TRAFFIC_STEADY;
        errors           = 0;
        frames_sent      = 0;
        accepted_bytes   = 0;
        statuses_checked = 0;
        pressure_done    = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        active_cfg = '0;
        clear_frame();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_cfg)
            begin
                wait_drained();
                load_config(directed_rows[i].cfg);
            end
            typed_pending = directed_rows[i].typed;
            typed_status  = directed_rows[i].status;
            send_frame(directed_rows[i].shape, int'(directed_rows[i].extent),
                       directed_rows[i].flaws, directed_rows[i].fill);
        end

        // Random part: short frames with random flaws, checked on status and partial CRC.
        random_start_bytes  = accepted_bytes;
        random_start_frames = frames_sent;
        while (accepted_bytes - random_start_bytes < RANDOM_BYTES ||
               frames_sent - random_start_frames < RANDOM_FRAMES)
        begin
            if ((frames_sent - random_start_frames) % 10 == 0)
            begin
                wait_drained();
                c.magic_word        = pick_word();
                c.version_expected  = 8'(pick_word());
                c.msg_type_expected = 8'(pick_word());
                load_config(c);
            end
            if (!pressure_done && frames_sent - random_start_frames == 5)
            begin
                // Stall the sink while single-byte frames keep arriving.
                pressure_done = 1'b1;
                traffic_mode  = TRAFFIC_STEADY;
                hold_request  = 1'b1;
                repeat (BURST_FRAMES)
                begin
                    send_byte(8'($urandom), 1'b1);
                    frames_sent++;
                end
            end
            roll = $urandom_range(99);
            if (roll < 70)
                send_frame(FRAME_SHORT, $urandom_range(1, 24), 5'($urandom), FILL_RANDOM);
            else
                send_frame(FRAME_SHORT, $urandom_range(25, 40), 5'($urandom), FILL_RANDOM);
        end

        wait_drained();
        $display("covered %0d frames, %0d bytes in frame, %0d statuses checked",
                 frames_sent, accepted_bytes, statuses_checked);
        $display("status mix ok %0d size %0d magic %0d version %0d type %0d length %0d crc %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (errors == 0)
            $display("tb_frame_header_crc_verifier passed");
        else
            $display("tb_frame_header_crc_verifier failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/fhcv_pkg.sv
rtl/core/fhcv_if.sv
rtl/core/fhcv_crc_step.sv
rtl/core/fhcv_msg_state.sv
rtl/core/frame_header_crc_verifier.sv
dv/tb_frame_header_crc_verifier.sv
